// ===== rtl/hcpm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcpm_pkg
// Shared constants, types and fp32/bf16 arithmetic helpers for the post-mix
// pipeline.
// ----------------------------------------------------------------------------
package hcpm_pkg;

  localparam int NPORT       = 4;
  localparam int STREAMS_DEF = 4;
  localparam int IDX_W       = 5;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MIX  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic               nan;
    logic               inf;
    logic               zero;
    logic               sign;
    logic signed [10:0] be;
    logic [31:0]        mant;
  } fp_raw_t;

  function automatic logic [5:0] lzc32(input logic [31:0] m);
    logic [5:0] lz;
    lz = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) lz = 6'(31 - i);
    end
    return lz;
  endfunction

  // exact product of an fp32 and a bf16, not yet normalized
  function automatic fp_raw_t mul_raw(input logic [31:0] a, input logic [15:0] b);
    fp_raw_t    r;
    logic [7:0] ea, eb, eae, ebe;
    logic       a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
    logic [23:0] ma;
    logic [7:0]  mb;
    ea     = a[30:23];
    eb     = b[14:7];
    a_nan  = (ea == 8'hFF) && (a[22:0] != '0);
    a_inf  = (ea == 8'hFF) && (a[22:0] == '0);
    a_zero = (ea == 8'h00) && (a[22:0] == '0);
    b_nan  = (eb == 8'hFF) && (b[6:0] != '0);
    b_inf  = (eb == 8'hFF) && (b[6:0] == '0);
    b_zero = (eb == 8'h00) && (b[6:0] == '0);
    eae    = (ea == 8'h00) ? 8'd1 : ea;
    ebe    = (eb == 8'h00) ? 8'd1 : eb;
    ma     = {(ea != 8'h00), a[22:0]};
    mb     = {(eb != 8'h00), b[6:0]};
    r.sign = a[31] ^ b[15];
    r.nan  = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    r.inf  = a_inf | b_inf;
    r.zero = a_zero | b_zero;
    r.mant = {8'd0, ma} * {24'd0, mb};
    r.be   = $signed({3'd0, eae}) + $signed({3'd0, ebe}) - 11'sd126;
    return r;
  endfunction

  // aligned sum of two fp32 values with guard, round and sticky bits
  function automatic fp_raw_t add_raw(input logic [31:0] a, input logic [31:0] b);
    fp_raw_t     r;
    logic        a_nan, a_inf, b_nan, b_inf, swap;
    logic [31:0] x, y;
    logic [7:0]  exe, eye, d;
    logic [4:0]  dd;
    logic [26:0] mx, my, mys;
    logic [58:0] ext;
    logic [27:0] s;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    swap  = b[30:0] > a[30:0];
    x     = swap ? b : a;
    y     = swap ? a : b;
    exe   = (x[30:23] == 8'h00) ? 8'd1 : x[30:23];
    eye   = (y[30:23] == 8'h00) ? 8'd1 : y[30:23];
    d     = exe - eye;
    dd    = (d > 8'd31) ? 5'd31 : d[4:0];
    mx    = {(x[30:23] != 8'h00), x[22:0], 3'd0};
    my    = {(y[30:23] != 8'h00), y[22:0], 3'd0};
    ext   = {my, 32'd0} >> dd;
    mys   = {ext[58:33], ext[32] | (|ext[31:0])};
    if (x[31] == y[31]) begin
      s = {1'b0, mx} + {1'b0, mys};
    end else begin
      s = {1'b0, mx} - {1'b0, mys};
    end
    r.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    r.inf  = a_inf | b_inf;
    r.zero = 1'b0;
    if (a_inf | b_inf) begin
      r.sign = a_inf ? a[31] : b[31];
    end else if (s == '0) begin
      r.sign = a[31] & b[31];
    end else begin
      r.sign = x[31];
    end
    r.mant = {4'd0, s};
    r.be   = $signed({3'd0, exe}) + 11'sd5;
    return r;
  endfunction

  // normalize and round to fp32, round-to-nearest-even, subnormals kept
  function automatic logic [31:0] norm_round(input fp_raw_t r);
    logic [5:0]         lz, sh;
    logic [31:0]        mn, kept;
    logic signed [10:0] e, shf;
    logic [63:0]        ext;
    logic               sticky, inc;
    logic [7:0]         expf;
    logic [30:0]        sum;
    logic [31:0]        res;
    lz     = lzc32(r.mant);
    mn     = r.mant << lz;
    e      = r.be - $signed({5'd0, lz});
    shf    = 11'sd1 - e;
    sh     = (shf > 11'sd63) ? 6'd63 : shf[5:0];
    ext    = {mn, 32'd0} >> sh;
    if (e >= 11'sd1) begin
      kept   = mn;
      sticky = 1'b0;
      expf   = e[7:0];
    end else begin
      kept   = ext[63:32];
      sticky = |ext[31:0];
      expf   = 8'd0;
    end
    sticky = sticky | (|kept[6:0]);
    inc    = kept[7] & (sticky | kept[8]);
    sum    = {expf, kept[30:8]} + {30'd0, inc};
    if (r.nan) begin
      res = 32'h7FC0_0000;
    end else if (r.inf || (!(r.zero || (r.mant == '0)) && (e >= 11'sd255))) begin
      res = {r.sign, 8'hFF, 23'd0};
    end else if (r.zero || (r.mant == '0)) begin
      res = {r.sign, 31'd0};
    end else begin
      res = {r.sign, sum};
    end
    return res;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] s;
    s = u + 32'h0000_7FFF + {31'd0, u[16]};
    if ((u[30:23] == 8'hFF) && (u[22:0] != '0)) begin
      return 16'h7FC0;
    end
    return s[31:16];
  endfunction

endpackage

// ===== rtl/hcpm_weights.sv =====
// ----------------------------------------------------------------------------
// hcpm_weights
// Register file for post weights and the combine matrix; one write per cycle,
// every entry visible at once.
// ----------------------------------------------------------------------------
module hcpm_weights import hcpm_pkg::*; #(
  parameter int WCOUNT = STREAMS_DEF + STREAMS_DEF * STREAMS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [IDX_W-1:0]         waddr,
  input  logic [31:0]              wdata,
  output logic [WCOUNT-1:0][31:0]  weights
);

  logic [WCOUNT-1:0][31:0] w_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < WCOUNT; i++) begin
      if (we && (int'(waddr) == i)) begin
        w_r[i] <= wdata;
      end
    end
  end

  assign weights = w_r;

endmodule

// ===== rtl/hcpm_product.sv =====
// ----------------------------------------------------------------------------
// hcpm_product
// All weight-by-input products: multiply stage, then normalize-and-round stage.
// ----------------------------------------------------------------------------
module hcpm_product import hcpm_pkg::*; #(
  parameter  int STREAMS = STREAMS_DEF,
  localparam int LANES   = (STREAMS < NPORT) ? STREAMS : NPORT,
  localparam int WCOUNT  = STREAMS + STREAMS * STREAMS
) (
  input  logic                                  clk,
  input  logic [1:0]                            en,
  input  logic [15:0]                           layer,
  input  logic [STREAMS-1:0][15:0]              streams,
  input  logic [WCOUNT-1:0][31:0]               weights,
  output logic [LANES-1:0][31:0]                post_p,
  output logic [STREAMS-1:0][LANES-1:0][31:0]   comb_p
);

  fp_raw_t                           post_raw_r [LANES];
  fp_raw_t                           comb_raw_r [STREAMS][LANES];
  logic [LANES-1:0][31:0]            post_r;
  logic [STREAMS-1:0][LANES-1:0][31:0] comb_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < LANES; j++) begin
      if (en[0]) post_raw_r[j] <= mul_raw(weights[j], layer);
      if (en[1]) post_r[j] <= norm_round(post_raw_r[j]);
      for (int k = 0; k < STREAMS; k++) begin
        if (en[0]) comb_raw_r[k][j] <= mul_raw(weights[STREAMS + STREAMS * k + j], streams[k]);
        if (en[1]) comb_r[k][j] <= norm_round(comb_raw_r[k][j]);
      end
    end
  end

  assign post_p = post_r;
  assign comb_p = comb_r;

endmodule

// ===== rtl/hcpm_lane.sv =====
// ----------------------------------------------------------------------------
// hcpm_lane
// Accumulation chain for one output: per stream an align/add stage and a
// normalize/round stage, products carried alongside.
// ----------------------------------------------------------------------------
module hcpm_lane import hcpm_pkg::*; #(
  parameter int STREAMS = STREAMS_DEF
) (
  input  logic                       clk,
  input  logic [2*STREAMS-1:0]       en,
  input  logic [31:0]                post_p,
  input  logic [STREAMS-1:0][31:0]   comb_p,
  output logic [31:0]                acc
);

  fp_raw_t                   raw_r [STREAMS];
  logic [31:0]               acc_r [STREAMS];
  logic [STREAMS-1:0][31:0]  cpa_r [STREAMS];
  logic [STREAMS-1:0][31:0]  cp_r  [STREAMS];

  for (genvar k = 0; k < STREAMS; k++) begin : g_step
    logic [31:0]              acc_in;
    logic [STREAMS-1:0][31:0] cp_in;
    if (k == 0) begin : g_first
      assign acc_in = post_p;
      assign cp_in  = comb_p;
    end else begin : g_next
      assign acc_in = acc_r[k-1];
      assign cp_in  = cp_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en[2*k]) begin
        raw_r[k] <= add_raw(acc_in, cp_in[k]);
        cpa_r[k] <= cp_in;
      end
      if (en[2*k+1]) begin
        acc_r[k] <= norm_round(raw_r[k]);
        cp_r[k]  <= cpa_r[k];
      end
    end
  end

  assign acc = acc_r[STREAMS-1];

endmodule

// ===== rtl/hyper_connection_post_mix_unit.sv =====
// ----------------------------------------------------------------------------
// hyper_connection_post_mix_unit
// Post-mix of a multi-stream hyper-connection: loads fp32 mixing weights and
// mixes bf16 layer and residual values into bf16 output streams.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  command, weight index/bits, values
//   out_     output     out_valid / out_stall four mixed bf16 values, token_done
//
// One item per cycle sustained while out_stall stays low. A mix item passes
// through two product stages, two stages per accumulation step and one
// output register. A load item writes the weight register file at
// acceptance and yields no result.
// Reset clears only the stage valid bits; weights are undefined until loaded.
// Each stage holds under stall only if the stage after it is full, so bubbles
// close up and the input stalls only when every stage holds an item.
// ----------------------------------------------------------------------------
module hyper_connection_post_mix_unit import hcpm_pkg::*; #(
  parameter int STREAMS = STREAMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [IDX_W-1:0]  in_weight_index,
  input  logic [31:0]       in_weight_bits,
  input  logic [15:0]       in_layer_value,
  input  logic [15:0]       in_stream_zero,
  input  logic [15:0]       in_stream_one,
  input  logic [15:0]       in_stream_two,
  input  logic [15:0]       in_stream_three,
  input  logic              in_last_position,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_mixed_zero,
  output logic [15:0]       out_mixed_one,
  output logic [15:0]       out_mixed_two,
  output logic [15:0]       out_mixed_three,
  output logic              out_token_done
);

  localparam int LANES  = (STREAMS < NPORT) ? STREAMS : NPORT;
  localparam int WCOUNT = STREAMS + STREAMS * STREAMS;
  localparam int NSTG   = 2 * STREAMS + 3;

  logic [NSTG-1:0]                       v_r, v_nxt, en;
  logic [NSTG-1:0]                       last_r;
  logic                                  in_acc, mix_acc, load_acc;
  logic [NPORT-1:0][15:0]                in_arr;
  logic [STREAMS-1:0][15:0]              streams;
  logic [WCOUNT-1:0][31:0]               weights;
  logic [LANES-1:0][31:0]                post_p;
  logic [STREAMS-1:0][LANES-1:0][31:0]   comb_p;
  logic [LANES-1:0][31:0]                acc;
  logic [NPORT-1:0][15:0]                mixed_r;

  assign in_acc   = in_valid && !in_stall;
  assign mix_acc  = in_acc && (cmd_t'(in_command) == CMD_MIX);
  assign load_acc = in_acc && (cmd_t'(in_command) == CMD_LOAD);
  assign in_arr   = {in_stream_three, in_stream_two, in_stream_one, in_stream_zero};

  for (genvar k = 0; k < STREAMS; k++) begin : g_in
    if (k < NPORT) begin : g_port
      assign streams[k] = in_arr[k];
    end else begin : g_none
      assign streams[k] = '0;
    end
  end

  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    if (en[0]) begin
      v_nxt[0] = mix_acc;
    end else begin
      v_nxt[0] = v_r[0];
    end
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) begin
        v_nxt[i] = v_r[i-1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) last_r[0] <= in_last_position;
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) last_r[i] <= last_r[i-1];
    end
  end

  hcpm_weights #(.WCOUNT(WCOUNT)) u_weights (
    .clk     (clk),
    .we      (load_acc),
    .waddr   (in_weight_index),
    .wdata   (in_weight_bits),
    .weights (weights)
  );

  hcpm_product #(.STREAMS(STREAMS)) u_product (
    .clk     (clk),
    .en      (en[1:0]),
    .layer   (in_layer_value),
    .streams (streams),
    .weights (weights),
    .post_p  (post_p),
    .comb_p  (comb_p)
  );

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [STREAMS-1:0][31:0] comb_col;
    for (genvar k = 0; k < STREAMS; k++) begin : g_col
      assign comb_col[k] = comb_p[k][j];
    end
    hcpm_lane #(.STREAMS(STREAMS)) u_lane (
      .clk    (clk),
      .en     (en[2*STREAMS+1:2]),
      .post_p (post_p[j]),
      .comb_p (comb_col),
      .acc    (acc[j])
    );
  end

  for (genvar j = 0; j < NPORT; j++) begin : g_out
    if (j < LANES) begin : g_live
      always_ff @(posedge clk) begin
        if (en[NSTG-1]) mixed_r[j] <= to_bf16(acc[j]);
      end
    end else begin : g_dead
      always_ff @(posedge clk) begin
        if (en[NSTG-1]) mixed_r[j] <= '0;
      end
    end
  end

  assign out_valid       = v_r[NSTG-1];
  assign out_mixed_zero  = mixed_r[0];
  assign out_mixed_one   = mixed_r[1];
  assign out_mixed_two   = mixed_r[2];
  assign out_mixed_three = mixed_r[3];
  assign out_token_done  = last_r[NSTG-1];

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled while pipeline has room");

  a_mix_enters: assert property (@(posedge clk) disable iff (!rst_n)
    mix_acc |=> v_r[0])
    else $error("accepted mix item not in first stage");

  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v_r[NSTG-2]) |=> !out_valid)
    else $error("result repeated after hand-off");

endmodule

// ===== tb/hcpm_checker.sv =====
// ----------------------------------------------------------------------------
// hcpm_checker
// Watches both channels of the post-mix unit. It keeps its own copy of the
// weight store, predicts the four bf16 mixed values for every mix item with
// separately rounded fp32 products and sums, and compares each output item,
// in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module hcpm_checker import hcpm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_command,
  input  logic [IDX_W-1:0] in_weight_index,
  input  logic [31:0]      in_weight_bits,
  input  logic [15:0]      in_layer_value,
  input  logic [15:0]      in_stream_zero,
  input  logic [15:0]      in_stream_one,
  input  logic [15:0]      in_stream_two,
  input  logic [15:0]      in_stream_three,
  input  logic             in_last_position,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [15:0]      out_mixed_zero,
  input  logic [15:0]      out_mixed_one,
  input  logic [15:0]      out_mixed_two,
  input  logic [15:0]      out_mixed_three,
  input  logic             out_token_done,
  output int               errors,
  output int               pending,
  output int               loads_seen,
  output int               mixes_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWEIGHT = NPORT + NPORT * NPORT;

  typedef struct packed {
    logic [3:0][15:0] mixed;
    logic             token_done;
  } mix_result_t;

  logic [31:0] weight_store [NWEIGHT];
  mix_result_t mix_results_due [$];

  function automatic real fp32_value(input logic [31:0] b);
    real v;
    if (b[30:23] == 8'hFF) return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    if (b[30:23] == 8'h00) begin
      if (b[22:0] == '0) return $bitstoreal({b[31], 63'd0});
      v = real'(b[22:0]) * 2.0 ** (-149);
      return b[31] ? -v : v;
    end
    return $bitstoreal({b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] round_fp32(input real v);
    logic [63:0] d, m, q, rem, half;
    logic [31:0] body;
    int          e, sh;
    logic        inc;
    d = $realtobits(v);
    if (d[62:52] == 11'h7FF) return (d[51:0] != '0) ? 32'h7FC0_0000 : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'h000) return {d[63], 31'd0};
    e = int'(d[62:52]) - 896;
    if (e >= 255) return {d[63], 8'hFF, 23'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    sh = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) sh = 60;
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    inc  = (rem > half) || ((rem == half) && q[0]);
    body = (e >= 1) ? {1'b0, 8'(e), q[22:0]} : q[31:0];
    body = body + {31'd0, inc};
    return {d[63], body[30:0]};
  endfunction

  function automatic logic [15:0] round_bf16(input logic [31:0] u);
    logic [31:0] s;
    if ((u[30:23] == 8'hFF) && (u[22:0] != '0)) return 16'h7FC0;
    s = u + 32'h0000_7FFF + {31'd0, u[16]};
    return s[31:16];
  endfunction

  function automatic mix_result_t predict_mix(input logic [15:0] layer,
                                              input logic [3:0][15:0] streams,
                                              input logic last);
    mix_result_t res;
    logic [31:0] acc, prod;
    real         x;
    x = fp32_value({layer, 16'd0});
    for (int j = 0; j < NPORT; j++) begin
      acc = round_fp32(fp32_value(weight_store[j]) * x);
      for (int k = 0; k < NPORT; k++) begin
        prod = round_fp32(fp32_value(weight_store[NPORT + NPORT * k + j]) *
                          fp32_value({streams[k], 16'd0}));
        acc  = round_fp32(fp32_value(acc) + fp32_value(prod));
      end
      res.mixed[j] = round_bf16(acc);
    end
    res.token_done = last;
    return res;
  endfunction

  always @(posedge clk) begin
    mix_result_t got, want;
    if (!rst_n) begin
      errors        = 0;
      loads_seen    = 0;
      mixes_checked = 0;
      mix_results_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (in_command == CMD_LOAD) begin
          loads_seen++;
          if (in_weight_index < NWEIGHT) weight_store[in_weight_index] = in_weight_bits;
        end else begin
          mix_results_due.push_back(predict_mix(in_layer_value,
            {in_stream_three, in_stream_two, in_stream_one, in_stream_zero},
            in_last_position));
        end
      end
      if (out_valid && !out_stall) begin
        got.mixed      = {out_mixed_three, out_mixed_two, out_mixed_one, out_mixed_zero};
        got.token_done = out_token_done;
        if (mix_results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected output item %h", $realtime, got);
        end else begin
          want = mix_results_due.pop_front();
          mixes_checked++;
          for (int j = 0; j < NPORT; j++) begin
            if (got.mixed[j] !== want.mixed[j]) begin
              errors++;
              $display("%0t: mixed[%0d] expected %h actual %h", $realtime, j,
                       want.mixed[j], got.mixed[j]);
            end
          end
          if (got.token_done !== want.token_done) begin
            errors++;
            $display("%0t: token_done expected %b actual %b", $realtime,
                     want.token_done, got.token_done);
          end
        end
      end
    end
    pending = mix_results_due.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the post-mix unit: loads a full weight set, runs directed mixes
// on special values (zeros, subnormals, infinities, NaN, overflow), then a
// long random mix of weight reloads and mix items under random idling on
// both channels. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import hcpm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NWEIGHT = NPORT + NPORT * NPORT;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_command = CMD_LOAD;
  logic [IDX_W-1:0] in_weight_index = '0;
  logic [31:0]      in_weight_bits = '0;
  logic [15:0]      in_layer_value = '0;
  logic [15:0]      in_stream_zero = '0;
  logic [15:0]      in_stream_one = '0;
  logic [15:0]      in_stream_two = '0;
  logic [15:0]      in_stream_three = '0;
  logic             in_last_position = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [15:0]      out_mixed_zero, out_mixed_one, out_mixed_two, out_mixed_three;
  logic             out_token_done;
  int               errors, pending, loads_seen, mixes_checked;
  int               cycle = 0;
  int               item_no = 0;
  int               wait_cycles;

  always #5 clk = ~clk;

  hyper_connection_post_mix_unit uut (.*);
  hcpm_checker checker_i (.*);

  always @(negedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 1200 && cycle < 1500) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 14);
  end

  function automatic logic [31:0] rand_weight();
    if ($urandom_range(0, 9) < 7)
      return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
    return $urandom;
  endfunction

  function automatic logic [15:0] rand_bf16();
    if ($urandom_range(0, 9) < 8)
      return {1'($urandom), 8'($urandom_range(100, 150)), 7'($urandom)};
    return 16'($urandom);
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [IDX_W-1:0] idx,
                           input logic [31:0] wbits, input logic [15:0] layer,
                           input logic [3:0][15:0] st, input logic last);
    if (!(item_no > 400 && item_no < 600) && $urandom_range(0, 99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command       = cmd;
    in_weight_index  = idx;
    in_weight_bits   = wbits;
    in_layer_value   = layer;
    in_stream_zero   = st[0];
    in_stream_one    = st[1];
    in_stream_two    = st[2];
    in_stream_three  = st[3];
    in_last_position = last;
    in_valid         = 1'b1;
    do @(posedge clk); while (in_stall);
    item_no++;
    @(negedge clk);
  endtask

  task automatic load_weight(input int idx, input logic [31:0] wbits);
    send_item(CMD_LOAD, IDX_W'(idx), wbits, 16'($urandom), 64'({$urandom, $urandom}),
              1'($urandom));
  endtask

  task automatic mix(input logic [15:0] layer, input logic [3:0][15:0] st, input logic last);
    send_item(CMD_MIX, IDX_W'($urandom), $urandom, layer, st, last);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NWEIGHT; i++) load_weight(i, 32'h3F80_0000);
    mix(16'h3F80, {16'h4000, 16'hC000, 16'h0000, 16'h8000}, 1'b0);
    mix(16'h0000, {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b1);
    mix(16'h7F7F, {16'h7F7F, 16'h7F7F, 16'h7F7F, 16'h7F7F}, 1'b0);
    mix(16'h7F80, {16'hFF80, 16'h0000, 16'h0000, 16'h0000}, 1'b1);
    mix(16'h7FC1, {16'h0001, 16'h8001, 16'h007F, 16'hFFFF}, 1'b0);
    load_weight(0, 32'h0000_0001);
    load_weight(5, 32'h7F7F_FFFF);
    load_weight(9, 32'h8000_0000);
    load_weight(21, 32'h7FC0_0000);
    load_weight(31, 32'hFFFF_FFFF);
    load_weight(1, 32'h7F80_0000);
    mix(16'h0001, {16'h3F80, 16'h0000, 16'h0080, 16'h0000}, 1'b1);
    mix(16'h0000, {16'h7F80, 16'h3F80, 16'h3F80, 16'h3F80}, 1'b0);
    mix(16'hFFFF, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1);

    for (int n = 0; n < 1150; n++) begin
      if ($urandom_range(0, 3) == 0)
        load_weight(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(0, NWEIGHT - 1),
                    rand_weight());
      else
        mix(rand_bf16(), {rand_bf16(), rand_bf16(), rand_bf16(), rand_bf16()},
            ($urandom_range(0, 3) == 0));
    end
    in_valid = 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (30) @(posedge clk);
    $display("Covered %0d weight loads and %0d checked mix results (%0d still due).",
             loads_seen, mixes_checked, pending);
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout at %0t", $realtime);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hcpm_pkg.sv
rtl/hcpm_weights.sv
rtl/hcpm_product.sv
rtl/hcpm_lane.sv
rtl/hyper_connection_post_mix_unit.sv
tb/hcpm_checker.sv
tb/tb.sv
